// File: rtl/core/mhpq_pkg.sv
package mhpq_pkg;

    localparam int CAPACITY = 4096;
    localparam int KEY_BITS = 64;
    localparam int TAG_BITS = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = CNT_W;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    typedef struct packed {
        t_opcode opcode;
        t_entry  entry;
    } t_cmd;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] count;
        t_entry           removed;
        logic             top_valid;
        t_entry           top;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DN_LAST,
        S_DN_L,
        S_DN_R,
        S_FIN,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        PICK_NONE,
        PICK_LEFT,
        PICK_RIGHT
    } t_pick;

endpackage

// File: rtl/core/mhpq_req_if.sv
interface mhpq_req_if import mhpq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;

    modport source (output valid, output opcode, output key, output tag, input ready);
    modport sink   (input valid, input opcode, input key, input tag, output ready);
endinterface

// File: rtl/core/mhpq_rsp_if.sv
interface mhpq_rsp_if import mhpq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [CNT_W-1:0]    count;
    logic [KEY_BITS-1:0] removed_key;
    logic [TAG_BITS-1:0] removed_tag;
    logic                top_valid;
    logic [KEY_BITS-1:0] top_key;
    logic [TAG_BITS-1:0] top_tag;

    modport source (
        output valid, output status, output count, output removed_key,
        output removed_tag, output top_valid, output top_key, output top_tag,
        input ready
    );
    modport sink (
        input valid, input status, input count, input removed_key,
        input removed_tag, input top_valid, input top_key, input top_tag,
        output ready
    );
endinterface

// File: rtl/core/mhpq_engine.sv
module mhpq_engine import mhpq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_cmd    i_cmd,
    output logic    o_res_valid,
    input  logic    i_res_take,
    output t_result o_res
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;
    t_entry r_top;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_pos, n_pos;
    t_entry           r_cur, n_cur;
    t_entry           r_best, n_best;
    logic             r_lsel, n_lsel;
    t_status          r_status, n_status;
    t_entry           r_rem, n_rem;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_entry            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [POS_W-1:0] pos_m1;
    logic [POS_W-1:0] ins_pos;
    logic [POS_W-1:0] ins_par_m1;
    logic [POS_W-1:0] up_par;
    logic [POS_W-1:0] up_gpar_m1;
    logic [POS_W:0]   lc;
    logic [POS_W:0]   rc;
    logic [POS_W:0]   n_ext;
    logic [POS_W:0]   new_pos;
    logic [POS_W:0]   new_lc;
    logic [POS_W:0]   new_lc_m1;
    logic [CNT_W-1:0] last_m1;
    logic             cur_lt_rd;
    logic             best_lt_rd;
    t_pick            pick;
    t_entry           pick_val;
    logic             do_resolve;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // shadow copy of the root
    always_ff @(posedge i_clk) begin
        if (mem_we && mem_waddr == '0) begin
            r_top <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_best   <= n_best;
        r_lsel   <= n_lsel;
        r_status <= n_status;
        r_rem    <= n_rem;
    end

    always_comb begin
        pos_m1     = r_pos - 1'b1;
        ins_pos    = r_count + 1'b1;
        ins_par_m1 = (ins_pos >> 1) - 1'b1;
        up_par     = r_pos >> 1;
        up_gpar_m1 = (up_par >> 1) - 1'b1;
        lc         = {r_pos, 1'b0};
        rc         = lc + 1'b1;
        n_ext      = {1'b0, r_count};
        last_m1    = r_count - 1'b1;
        cur_lt_rd  = $signed(r_rdata.key) > $signed(r_cur.key);
        best_lt_rd = $signed(r_rdata.key) > $signed(r_best.key);
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_cur      = r_cur;
        n_best     = r_best;
        n_lsel     = r_lsel;
        n_status   = r_status;
        n_rem      = r_rem;
        mem_we     = 1'b0;
        mem_waddr  = pos_m1[ADDR_W-1:0];
        mem_wdata  = r_cur;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        pick       = PICK_NONE;
        pick_val   = r_rdata;
        do_resolve = 1'b0;
        new_pos    = '0;
        new_lc     = '0;
        new_lc_m1  = '0;
        o_cmd_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_status = ST_DONE;
                    n_rem    = '0;
                    if (i_cmd.opcode == OP_PUSH) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_RESULT;
                        end else begin
                            n_count = ins_pos;
                            n_cur   = i_cmd.entry;
                            n_pos   = ins_pos;
                            if (r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = i_cmd.entry;
                                n_state   = S_RESULT;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = ins_par_m1[ADDR_W-1:0];
                                n_state   = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESULT;
                        end else begin
                            n_rem   = r_top;
                            n_count = last_m1;
                            if (last_m1 == '0) begin
                                n_state = S_RESULT;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = last_m1[ADDR_W-1:0];
                                n_state   = S_DN_LAST;
                            end
                        end
                    end
                end
            end
            S_UP: begin
                // hole moves up while the new key beats the parent
                if ($signed(r_cur.key) > $signed(r_rdata.key)) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata;
                    n_pos     = up_par;
                    if (up_par == POS_W'(1)) begin
                        n_state = S_FIN;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = up_gpar_m1[ADDR_W-1:0];
                    end
                end else begin
                    mem_we  = 1'b1;
                    n_state = S_RESULT;
                end
            end
            S_DN_LAST: begin
                n_cur = r_rdata;
                n_pos = POS_W'(1);
                if (r_count >= CNT_W'(2)) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(1);
                    n_state   = S_DN_L;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_L: begin
                if (rc <= n_ext) begin
                    n_best    = cur_lt_rd ? r_rdata : r_cur;
                    n_lsel    = cur_lt_rd;
                    mem_re    = 1'b1;
                    mem_raddr = lc[ADDR_W-1:0];
                    n_state   = S_DN_R;
                end else begin
                    do_resolve = 1'b1;
                    pick       = cur_lt_rd ? PICK_LEFT : PICK_NONE;
                    pick_val   = r_rdata;
                end
            end
            S_DN_R: begin
                do_resolve = 1'b1;
                if (best_lt_rd) begin
                    pick     = PICK_RIGHT;
                    pick_val = r_rdata;
                end else begin
                    pick     = r_lsel ? PICK_LEFT : PICK_NONE;
                    pick_val = r_best;
                end
            end
            S_FIN: begin
                mem_we  = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // one level of sift-down settled
        if (do_resolve) begin
            if (pick == PICK_NONE) begin
                mem_we  = 1'b1;
                n_state = S_RESULT;
            end else begin
                mem_we    = 1'b1;
                mem_wdata = pick_val;
                new_pos   = (pick == PICK_LEFT) ? lc : rc;
                new_lc    = {new_pos[POS_W-1:0], 1'b0};
                new_lc_m1 = new_lc - 1'b1;
                n_pos     = new_pos[POS_W-1:0];
                if (new_lc <= n_ext) begin
                    mem_re    = 1'b1;
                    mem_raddr = new_lc_m1[ADDR_W-1:0];
                    n_state   = S_DN_L;
                end else begin
                    n_state = S_FIN;
                end
            end
        end
    end

    always_comb begin
        o_res.status    = r_status;
        o_res.count     = r_count;
        o_res.removed   = r_rem;
        o_res.top_valid = (r_count != '0);
        o_res.top       = (r_count != '0) ? r_top : '0;
    end

endmodule

// File: rtl/core/max_heap_priority_queue.sv
// channel  dir  modport  beat
// i_req    in   sink     opcode, key, tag
// o_rsp    out  source   status, count, removed_key/tag, top_valid, top_key/tag
//
// one operation at a time; push into an empty heap writes the root directly, otherwise the new entry
// climbs one level per parent read; pop down to empty writes nothing, otherwise the last entry is read
// and sifted down, reading the left and then the right child at each level
// the single read port of the entry memory sets this order: one child read per cycle
// the result sits in an output register, so a new beat is taken while it waits
// synchronous active-low reset empties the heap; memory contents are not cleared
module max_heap_priority_queue import mhpq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);

    t_cmd    core_cmd;
    logic    core_ready;
    logic    core_res_valid;
    logic    core_take;
    t_result core_res;
    logic    r_rsp_valid;
    t_result r_rsp;

    assign core_cmd.opcode    = t_opcode'(i_req.opcode);
    assign core_cmd.entry.key = i_req.key;
    assign core_cmd.entry.tag = i_req.tag;

    mhpq_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_req.valid),
        .o_cmd_ready (core_ready),
        .i_cmd       (core_cmd),
        .o_res_valid (core_res_valid),
        .i_res_take  (core_take),
        .o_res       (core_res)
    );

    assign i_req.ready = core_ready;
    assign core_take   = core_res_valid && (!r_rsp_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (core_take) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
        if (core_take) begin
            r_rsp <= core_res;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_rsp.status;
    assign o_rsp.count       = r_rsp.count;
    assign o_rsp.removed_key = r_rsp.removed.key;
    assign o_rsp.removed_tag = r_rsp.removed.tag;
    assign o_rsp.top_valid   = r_rsp.top_valid;
    assign o_rsp.top_key     = r_rsp.top.key;
    assign o_rsp.top_tag     = r_rsp.top.tag;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("beat taken while an operation is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.count <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_top_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.top_valid == (o_rsp.count != '0))
        else $error("top_valid disagrees with count");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status == ST_EMPTY |-> o_rsp.count == '0)
        else $error("empty pop reported with entries held");

endmodule
